// ----- rtl/pfsb_pkg.sv -----
// Shared types, codes and default sizes for the page frame buffer sprite blitter.
// No dependencies; used by every module of the block by scoped names.
package pfsb_pkg;

    // Default frame geometry
    localparam int PAGE_COUNT   = 8;
    localparam int COLUMN_COUNT = 128;

    // Depth of the op queue between front and back (power of two)
    localparam int QUEUE_DEPTH  = 4;

    // Actions carried by an item
    localparam logic [1:0] ACT_BLIT   = 2'd0;
    localparam logic [1:0] ACT_SPRITE = 2'd1;
    localparam logic [1:0] ACT_OR     = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // Memory op kinds
    localparam logic OP_OR   = 1'b0;
    localparam logic OP_READ = 1'b1;

    // One frame memory op; page and column are wide enough for up to 16 pages and 256 columns
    typedef struct packed {
        logic       kind;
        logic [3:0] page;
        logic [7:0] column;
        logic [7:0] data;
        logic       clear;
        logic       hit;
    } t_op;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ----- rtl/pfsb_front.sv -----
// Front end: accepts items, keeps blit state, clips and turns items into memory ops.
// Depends on pfsb_pkg.
module pfsb_front #(
    parameter int PAGE_COUNT   = pfsb_pkg::PAGE_COUNT,
    parameter int COLUMN_COUNT = pfsb_pkg::COLUMN_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_action,
    input  logic [5:0]           i_start_line,
    input  logic signed [7:0]    i_start_column,
    input  logic [7:0]           i_sprite_columns,
    input  logic [3:0]           i_sprite_pages,
    input  logic                 i_draw_order,
    input  logic [7:0]           i_data,
    input  logic [2:0]           i_page,
    input  logic [6:0]           i_column,
    input  logic                 i_clear_after,
    input  pfsb_pkg::t_queue_stat i_qstat,
    input  logic                 i_clearing,
    output logic                 o_busy,
    output logic                 o_push,
    output pfsb_pkg::t_op        o_op
);

    localparam logic [4:0] PG_LIM = 5'(PAGE_COUNT);
    localparam logic [9:0] CL_LIM = 10'(COLUMN_COUNT);

    // Blit state
    logic [2:0]    r_start_page;
    logic [2:0]    r_shift;
    logic [7:0]    r_left;
    logic [7:0]    r_width;
    logic [3:0]    r_height;
    logic          r_order;
    logic [7:0]    r_col_cnt, n_col_cnt;
    logic [3:0]    r_page_cnt, n_page_cnt;

    // Second half of a split sprite byte
    logic          r_pend_vld, n_pend_vld;
    pfsb_pkg::t_op r_pend_op, n_pend_op;

    logic          accept;
    logic          active;
    logic [9:0]    sp_col;
    logic [4:0]    sp_pg, sp_pg1;
    logic          col_ok;
    logic [15:0]   shifted;
    logic [4:0]    pc_inc;
    logic [8:0]    cc_inc;
    pfsb_pkg::t_op op0, op1;
    logic          op0_vld, op1_vld;

    assign o_busy = i_clearing | r_pend_vld | i_qstat.full;
    assign accept = i_start & ~o_busy;

    // Sprite byte placement and clipping
    always_comb begin
        active  = (r_width != 8'd0) && (r_height != 4'd0) &&
                  (r_order ? (r_page_cnt < r_height) : (r_col_cnt < r_width));
        sp_col  = {{2{r_left[7]}}, r_left} + {2'b00, r_col_cnt};
        sp_pg   = {2'b00, r_start_page} + {1'b0, r_page_cnt};
        sp_pg1  = sp_pg + 5'd1;
        col_ok  = ~sp_col[9] && (sp_col < CL_LIM);
        shifted = {8'h00, i_data} << r_shift;
        pc_inc  = {1'b0, r_page_cnt} + 5'd1;
        cc_inc  = {1'b0, r_col_cnt} + 9'd1;
    end

    // Op build for the accepted item
    always_comb begin
        op0        = '0;
        op1        = '0;
        op0_vld    = 1'b0;
        op1_vld    = 1'b0;
        n_col_cnt  = r_col_cnt;
        n_page_cnt = r_page_cnt;
        case (i_action)
            pfsb_pkg::ACT_SPRITE: begin
                op0.kind   = pfsb_pkg::OP_OR;
                op0.page   = sp_pg[3:0];
                op0.column = sp_col[7:0];
                op0.data   = shifted[7:0];
                op0.hit    = 1'b1;
                op1        = op0;
                op1.page   = sp_pg1[3:0];
                op1.data   = shifted[15:8];
                op0_vld    = active && col_ok && (sp_pg < PG_LIM);
                op1_vld    = active && col_ok && (sp_pg1 < PG_LIM) && (r_shift != 3'd0);
                if (active) begin
                    if (!r_order) begin
                        if (pc_inc >= {1'b0, r_height}) begin
                            n_page_cnt = 4'd0;
                            n_col_cnt  = cc_inc[7:0];
                        end else begin
                            n_page_cnt = pc_inc[3:0];
                        end
                    end else begin
                        if (cc_inc >= {1'b0, r_width}) begin
                            n_col_cnt  = 8'd0;
                            n_page_cnt = pc_inc[3:0];
                        end else begin
                            n_col_cnt  = cc_inc[7:0];
                        end
                    end
                end
            end
            pfsb_pkg::ACT_OR: begin
                op0.kind   = pfsb_pkg::OP_OR;
                op0.page   = {1'b0, i_page};
                op0.column = {1'b0, i_column};
                op0.data   = i_data;
                op0.hit    = 1'b1;
                op0_vld    = ({2'b00, i_page} < PG_LIM) && ({3'b000, i_column} < CL_LIM);
            end
            pfsb_pkg::ACT_READ: begin
                op0.kind   = pfsb_pkg::OP_READ;
                op0.page   = {1'b0, i_page};
                op0.column = {1'b0, i_column};
                op0.clear  = i_clear_after;
                op0.hit    = ({2'b00, i_page} < PG_LIM) && ({3'b000, i_column} < CL_LIM);
                op0_vld    = 1'b1;
            end
            default: begin
                // blit start: handled in the state update
            end
        endcase
    end

    // Queue push: accepted op first, held second half on a later cycle
    always_comb begin
        n_pend_vld = r_pend_vld;
        n_pend_op  = r_pend_op;
        o_push     = 1'b0;
        o_op       = r_pend_op;
        if (accept) begin
            o_push = op0_vld;
            o_op   = op0;
            if (op1_vld) begin
                n_pend_vld = 1'b1;
                n_pend_op  = op1;
            end
        end else if (r_pend_vld && !i_qstat.full) begin
            o_push     = 1'b1;
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_page <= '0;
            r_shift      <= '0;
            r_left       <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_order      <= 1'b0;
            r_col_cnt    <= '0;
            r_page_cnt   <= '0;
            r_pend_vld   <= 1'b0;
        end else begin
            r_pend_vld <= n_pend_vld;
            if (accept && i_action == pfsb_pkg::ACT_BLIT) begin
                r_start_page <= i_start_line[5:3];
                r_shift      <= i_start_line[2:0];
                r_left       <= i_start_column;
                r_width      <= i_sprite_columns;
                r_height     <= i_sprite_pages;
                r_order      <= i_draw_order;
                r_col_cnt    <= '0;
                r_page_cnt   <= '0;
            end else if (accept) begin
                r_col_cnt  <= n_col_cnt;
                r_page_cnt <= n_page_cnt;
            end
        end
    end

    // Payload only
    always_ff @(posedge i_clk) begin
        r_pend_op <= n_pend_op;
    end

endmodule

// ----- rtl/pfsb_queue.sv -----
// Short FIFO of memory ops between the front end and the back end.
// Depends on pfsb_pkg.
module pfsb_queue #(
    parameter int DEPTH = pfsb_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pfsb_pkg::t_op         i_op,
    input  logic                  i_pop,
    output pfsb_pkg::t_op         o_head,
    output pfsb_pkg::t_queue_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pfsb_pkg::t_op r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == (PW+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ----- rtl/pfsb_back.sv -----
// Back end: owns the single-port frame memory, clears it after reset and runs
// read-modify-write ops from the queue. Depends on pfsb_pkg.
module pfsb_back #(
    parameter int PAGE_COUNT   = pfsb_pkg::PAGE_COUNT,
    parameter int COLUMN_COUNT = pfsb_pkg::COLUMN_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfsb_pkg::t_op         i_head,
    input  pfsb_pkg::t_queue_stat i_qstat,
    output logic                  o_pop,
    output logic                  o_clearing,
    output logic                  o_valid,
    output logic [7:0]            o_pixel_byte,
    output logic [2:0]            o_read_page,
    output logic [6:0]            o_read_column
);

    localparam int DEPTH = PAGE_COUNT * COLUMN_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = AW + 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WR    = 2'd2;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr_cnt;
    pfsb_pkg::t_op r_op;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [MW-1:0] head_lin, op_lin;

    logic          r_valid;
    logic [7:0]    r_pixel;
    logic [2:0]    r_rpage;
    logic [6:0]    r_rcol;

    // Linear address: page * COLUMN_COUNT + column
    always_comb begin
        head_lin = MW'(i_head.page) * MW'(COLUMN_COUNT) + MW'(i_head.column);
        op_lin   = MW'(r_op.page) * MW'(COLUMN_COUNT) + MW'(r_op.column);
    end

    // Sequencer: clear pass, then read cycle and write cycle per op
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_addr  = head_lin[AW-1:0];
        mem_wdata = 8'h00;
        o_pop     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_cnt;
                if (r_clr_cnt == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                mem_addr = op_lin[AW-1:0];
                if (r_op.hit) begin
                    if (r_op.kind == pfsb_pkg::OP_OR) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rdata | r_op.data;
                    end else if (r_op.clear) begin
                        mem_we    = 1'b1;
                    end
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            r_valid <= (r_state == S_WR) && (r_op.kind == pfsb_pkg::OP_READ);
        end
    end

    // Op register and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_head;
        end
        if (r_state == S_WR) begin
            r_pixel <= r_op.hit ? r_rdata : 8'h00;
            r_rpage <= r_op.page[2:0];
            r_rcol  <= r_op.column[6:0];
        end
    end

    // Single-port frame memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    assign o_clearing    = (r_state == S_CLEAR);
    assign o_valid       = r_valid;
    assign o_pixel_byte  = r_pixel;
    assign o_read_page   = r_rpage;
    assign o_read_column = r_rcol;

endmodule

// ----- rtl/page_framebuffer_sprite_blitter_core.sv -----
// Top level of the page frame buffer sprite blitter: front end, op queue, back end.
// Depends on pfsb_pkg, pfsb_front, pfsb_queue and pfsb_back.

// A 1-bit frame buffer of PAGE_COUNT pages by COLUMN_COUNT columns held in one
// single-port memory. After reset the block holds busy high while it zeroes the
// memory. An item is taken when start is high and busy is low. The front end
// clips the item and queues up to two memory ops; the back end runs each op as
// a read cycle and a write cycle. A sprite byte that spills into the next page
// makes two ops; a blit start and a fully clipped byte make none. Items are
// taken back to back until the op queue fills, except that a sprite byte that
// spills holds busy while its second op goes into the queue. A read result is
// registered in the write state that follows the pop of its op and is shown on
// o_pixel_byte, o_read_page and o_read_column for exactly one cycle with
// o_valid high; there is no way to hold it off, so sample it then.
module page_framebuffer_sprite_blitter_core #(
    parameter int PAGE_COUNT   = pfsb_pkg::PAGE_COUNT,
    parameter int COLUMN_COUNT = pfsb_pkg::COLUMN_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_action,
    input  logic [5:0]        i_start_line,
    input  logic signed [7:0] i_start_column,
    input  logic [7:0]        i_sprite_columns,
    input  logic [3:0]        i_sprite_pages,
    input  logic              i_draw_order,
    input  logic [7:0]        i_data,
    input  logic [2:0]        i_page,
    input  logic [6:0]        i_column,
    input  logic              i_clear_after,
    output logic              o_valid,
    output logic [7:0]        o_pixel_byte,
    output logic [2:0]        o_read_page,
    output logic [6:0]        o_read_column
);

    logic                  q_push;
    logic                  q_pop;
    logic                  clearing;
    pfsb_pkg::t_op         push_op;
    pfsb_pkg::t_op         head_op;
    pfsb_pkg::t_queue_stat qstat;

    // Item intake and clipping
    pfsb_front #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_action         (i_action),
        .i_start_line     (i_start_line),
        .i_start_column   (i_start_column),
        .i_sprite_columns (i_sprite_columns),
        .i_sprite_pages   (i_sprite_pages),
        .i_draw_order     (i_draw_order),
        .i_data           (i_data),
        .i_page           (i_page),
        .i_column         (i_column),
        .i_clear_after    (i_clear_after),
        .i_qstat          (qstat),
        .i_clearing       (clearing),
        .o_busy           (busy),
        .o_push           (q_push),
        .o_op             (push_op)
    );

    // Op queue
    pfsb_queue #(
        .DEPTH (pfsb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .i_pop   (q_pop),
        .o_head  (head_op),
        .o_stat  (qstat)
    );

    // Frame memory and op execution
    pfsb_back #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_op),
        .i_qstat       (qstat),
        .o_pop         (q_pop),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .o_pixel_byte  (o_pixel_byte),
        .o_read_page   (o_read_page),
        .o_read_column (o_read_column)
    );

    // No item taken while the memory is being zeroed
    a_busy_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> busy)
        else $error("item could be taken during clear pass");

    // Queue never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !qstat.full)
        else $error("op queue overflow");

    // Each op runs through the idle state and the write state, so results never come back to back
    a_valid_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("read results on adjacent cycles");

    // Nothing leaves the queue while it is empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !qstat.empty)
        else $error("op queue underflow");

endmodule
